[design/priority_batch_scheduler_unit_macros.svh]
// assertion helpers used by the scheduler unit
`ifndef PRIORITY_BATCH_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_BATCH_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PBS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("scheduler check failed");
`define PBS_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("scheduler sequence check failed");
`else
`define PBS_ASSERT(lbl, prop)
`define PBS_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

[design/pbs_pkg.sv]
package pbs_pkg;

	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRI_W  = 8;
	localparam int LBL_W  = 5;
	localparam int COMP_W = 20;
	localparam int TAT_W  = 21;
	localparam int AVG_W  = 29;
	localparam int FRAC_W = 8;

	typedef struct packed {
		logic [LBL_W-1:0] label;
		logic [PRI_W-1:0] prio;
		logic [BUR_W-1:0] burst;
		logic [ARR_W-1:0] arrival;
	} job_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_I,
		S_LD_I,
		S_RD_J,
		S_CMP,
		S_WR_I,
		S_RD_K,
		S_OUT,
		S_GO_W,
		S_WAIT_W,
		S_GO_T,
		S_WAIT_T
	} state_t;

	typedef struct packed {
		logic go;
		logic fin;
	} div_ctl_t;

endpackage

[design/pbs_div.sv]
module pbs_div import pbs_pkg::*; #(
	parameter int DW = 35,
	parameter int NW = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic signed [DW-1:0] dividend,
	input  logic        [NW-1:0] divisor,
	output div_ctl_t             ctl,
	output logic signed [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic          neg_q;
	logic [NW:0]   trial;
	logic          fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			neg_q <= dividend[DW-1];
			quo_q <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
		end else if (busy_q) begin
			rem_q <= fits ? NW'(trial - {1'b0, divisor}) : trial[NW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign ctl.go    = busy_q;
	assign ctl.fin   = done_q;
	assign quotient  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

[design/priority_batch_scheduler_unit.sv]
// Jobs load one per start transfer (busy stays low) until a job with last_job
// set; then busy rises while a single comparator and a memory with separate
// read and write ports sort the batch, then the results are emitted one at a
// time, each read in S_RD_K and output in S_OUT. Before the final
// result two serial divisions run on one restoring divider, one quotient bit a
// cycle. Results appear on the result ports for a single cycle marked by
// result_valid and cannot be stalled; the last one carries both averages and
// last_result. overflow marks every result of a batch in which jobs beyond
// MAX_JOBS were dropped.
module priority_batch_scheduler_unit import pbs_pkg::*; #(
	parameter int MAX_JOBS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [ARR_W-1:0]         arrival_time,
	input  logic [BUR_W-1:0]         burst_time,
	input  logic [PRI_W-1:0]         priority_level,
	input  logic                     last_job,
	output logic                     result_valid,
	output logic [LBL_W-1:0]         job_number,
	output logic [COMP_W-1:0]        completion_time,
	output logic signed [TAT_W-1:0]  turnaround_time,
	output logic signed [TAT_W-1:0]  waiting_time,
	output logic signed [AVG_W-1:0]  avg_waiting,
	output logic signed [AVG_W-1:0]  avg_turnaround,
	output logic                     last_result,
	output logic                     overflow
);
`include "priority_batch_scheduler_unit_macros.svh"

	localparam int NW  = $clog2(MAX_JOBS + 1);
	localparam int IW  = $clog2(MAX_JOBS);
	localparam int CW  = BUR_W + NW;
	localparam int TW  = CW + 1;
	localparam int SW  = TW + NW;
	localparam int DW  = SW + FRAC_W;

	state_t state_q, state_d;

	job_t mem [MAX_JOBS];
	job_t rd_q;
	job_t cur_q;

	logic [NW-1:0] count_q;
	logic [NW-1:0] count_inc;
	logic [NW-1:0] i_q, j_q, k_q;
	logic [NW-1:0] i_nx, j_nx, k_nx;
	logic          dropped_q;
	logic [CW-1:0] run_q;
	logic signed [SW-1:0] wtot_q, ttot_q;
	logic signed [AVG_W-1:0] avgw_q;

	logic          accept;
	logic          we;
	logic [IW-1:0] waddr, raddr;
	job_t          wdata;
	logic          swap;

	logic [CW-1:0]        comp;
	logic signed [TW-1:0] tat, wt;

	logic                 div_go;
	logic signed [DW-1:0] div_in, div_q;
	div_ctl_t             div_ctl;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = state_q != S_IDLE;
	assign count_inc = (count_q < NW'(MAX_JOBS)) ? count_q + 1'b1 : count_q;
	assign i_nx      = i_q + 1'b1;
	assign j_nx      = j_q + 1'b1;
	assign k_nx      = k_q + 1'b1;
	assign swap      = cur_q.prio > rd_q.prio;

	assign comp = run_q + CW'(rd_q.burst);
	assign tat  = $signed({1'b0, comp}) - $signed(TW'(rd_q.arrival));
	assign wt   = tat - $signed(TW'(rd_q.burst));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && last_job)
					state_d = (count_inc == NW'(1)) ? S_RD_K : S_RD_I;
			end
			S_RD_I:   state_d = S_LD_I;
			S_LD_I:   state_d = S_RD_J;
			S_RD_J:   state_d = S_CMP;
			S_CMP:    state_d = (j_nx < count_q) ? S_RD_J : S_WR_I;
			S_WR_I:   state_d = (i_nx + 1'b1 < count_q) ? S_RD_I : S_RD_K;
			S_RD_K:   state_d = S_OUT;
			S_OUT:    state_d = (k_nx == count_q) ? S_GO_W : S_RD_K;
			S_GO_W:   state_d = S_WAIT_W;
			S_WAIT_W: state_d = div_ctl.fin ? S_GO_T : S_WAIT_W;
			S_GO_T:   state_d = S_WAIT_T;
			S_WAIT_T: state_d = div_ctl.fin ? S_IDLE : S_WAIT_T;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we     = 1'b0;
		waddr  = count_q[IW-1:0];
		wdata  = '{label: LBL_W'(count_q + 1'b1), prio: priority_level,
			burst: burst_time, arrival: arrival_time};
		raddr  = i_q[IW-1:0];
		div_go = 1'b0;
		div_in = DW'(wtot_q) <<< FRAC_W;
		case (state_q)
			S_IDLE: we = accept && (count_q < NW'(MAX_JOBS));
			S_RD_J: raddr = j_q[IW-1:0];
			S_CMP: begin
				// current holder of slot i goes back to slot j when it loses
				we    = swap;
				waddr = j_q[IW-1:0];
				wdata = cur_q;
			end
			S_WR_I: begin
				we    = 1'b1;
				waddr = i_q[IW-1:0];
				wdata = cur_q;
			end
			S_RD_K: raddr = k_q[IW-1:0];
			S_GO_W: div_go = 1'b1;
			S_GO_T: begin
				div_go = 1'b1;
				div_in = DW'(ttot_q) <<< FRAC_W;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	pbs_div #(.DW(DW), .NW(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_in),
		.divisor  (count_q),
		.ctl      (div_ctl),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			result_valid <= 1'b0;
			last_result  <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
		end else begin
			state_q      <= state_d;
			result_valid <= 1'b0;
			last_result  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_inc;
						if (count_q == NW'(MAX_JOBS))
							dropped_q <= 1'b1;
					end
					i_q <= '0;
					k_q <= '0;
				end
				S_LD_I: j_q <= i_nx;
				S_CMP:  j_q <= j_nx;
				S_WR_I: i_q <= i_nx;
				S_OUT: begin
					k_q <= k_nx;
					if (k_nx != count_q)
						result_valid <= 1'b1;
				end
				S_WAIT_T: begin
					if (div_ctl.fin) begin
						result_valid <= 1'b1;
						last_result  <= 1'b1;
						count_q      <= '0;
						dropped_q    <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			wtot_q <= '0;
			ttot_q <= '0;
		end else if (state_q == S_OUT) begin
			run_q  <= comp;
			wtot_q <= wtot_q + SW'(wt);
			ttot_q <= ttot_q + SW'(tat);
		end else if (state_q == S_IDLE) begin
			run_q  <= '0;
			wtot_q <= '0;
			ttot_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LD_I)
			cur_q <= rd_q;
		else if (state_q == S_CMP && swap)
			cur_q <= rd_q;
		if (state_q == S_OUT) begin
			job_number      <= rd_q.label;
			completion_time <= COMP_W'(comp);
			turnaround_time <= TAT_W'(tat);
			waiting_time    <= TAT_W'(wt);
			avg_waiting     <= '0;
			avg_turnaround  <= '0;
			overflow        <= dropped_q;
		end
		if (state_q == S_WAIT_W && div_ctl.fin)
			avgw_q <= AVG_W'(div_q);
		if (state_q == S_WAIT_T && div_ctl.fin) begin
			avg_waiting    <= avgw_q;
			avg_turnaround <= AVG_W'(div_q);
		end
	end

	`PBS_ASSERT(a_mid_busy, (result_valid && !last_result) |-> busy)
	`PBS_ASSERT_NEXT(a_last_busy, (accept && last_job), busy)
	`PBS_ASSERT_NEXT(a_last_single, (result_valid && last_result), !result_valid)
	`PBS_ASSERT(a_div_idle, div_go |-> !div_ctl.go)

endmodule
